// ===== src/pcc_pkg.sv =====
// Shared types, register indexes, mode codes and the surface palette of the point colouriser.
package pcc_pkg;

    typedef struct packed {
        logic               op;
        logic               first_of_scan;
        logic [19:0]        range_mm;
        logic signed [23:0] height_cm;
        logic signed [15:0] elevation_cdeg;
        logic signed [15:0] surface_id;
    } t_in_item;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_out_item;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] CFG_COLOR_MODE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SINGLE_COLOR = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MIN    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_RANGE_MAX    = 2'd3;

    localparam logic [2:0] MODE_SINGLE    = 3'd0;
    localparam logic [2:0] MODE_RANGE     = 3'd1;
    localparam logic [2:0] MODE_HEIGHT    = 3'd2;
    localparam logic [2:0] MODE_ELEVATION = 3'd3;

    localparam logic [2:0]  MODE_RESET   = MODE_RANGE;
    localparam logic [23:0] SINGLE_RESET = 24'hFFFFFF;
    localparam logic [19:0] RMIN_RESET   = 20'd0;
    localparam logic [19:0] RMAX_RESET   = 20'd100000;

    // Work kinds handed from the front end to the back end.
    localparam logic [1:0] KIND_DIRECT  = 2'd0;
    localparam logic [1:0] KIND_RAMP    = 2'd1;
    localparam logic [1:0] KIND_PALETTE = 2'd2;

    // How the ramp position is obtained.
    localparam logic [1:0] NORM_DIV  = 2'd0;
    localparam logic [1:0] NORM_ZERO = 2'd1;
    localparam logic [1:0] NORM_ONE  = 2'd2;
    localparam logic [1:0] NORM_HALF = 2'd3;

    localparam int NORM_W = 24;

    typedef struct packed {
        logic [1:0]        kind;
        logic [1:0]        norm;
        logic [23:0]       rgb;
        logic [NORM_W-1:0] num;
        logic [NORM_W-1:0] den;
        logic [14:0]       sid;
    } t_job;

    localparam logic [23:0] GRAY_RGB = 24'h808080;

    // floor(x / 12) = (x * 43691) >> 19 for every x below 2^15.
    localparam logic [16:0] MOD12_RECIP = 17'd43691;
    localparam int          MOD12_SHIFT = 19;

    function automatic logic [23:0] palette_rgb(input logic [3:0] idx);
        logic [23:0] c;
        unique case (idx)
            4'd0:    c = 24'hFF0000;
            4'd1:    c = 24'h00FF00;
            4'd2:    c = 24'h0000FF;
            4'd3:    c = 24'hFFFF00;
            4'd4:    c = 24'h00FFFF;
            4'd5:    c = 24'hFF00FF;
            4'd6:    c = 24'hFF8000;
            4'd7:    c = 24'h8000FF;
            4'd8:    c = 24'h008080;
            4'd9:    c = 24'hFF66B3;
            4'd10:   c = 24'h80FF00;
            4'd11:   c = 24'h8C5926;
            default: c = GRAY_RGB;
        endcase
        return c;
    endfunction

endpackage

// ===== src/point_cloud_colorizer.sv =====
// Top level of the lidar point colouriser: front end, job queue and back end.
// The block colours lidar points, each scan being sent twice. A measure transfer (op low)
// is absorbed by the front end in its cycle of acceptance and widens the height and
// elevation extents, or restarts them when first_of_scan is set; it produces no result.
// A colour transfer (op high) is classified at once against the configuration and the
// extents as they stand, and queued for the back end, so later measure points never
// disturb a colour already in flight. The back end takes one job at a time and finishes
// it before taking the next: a fixed colour or the grey of a negative surface id goes
// straight to the output state, a surface palette entry passes through a palette step,
// a clamped or mid-span ramp through the channel and conversion steps, and a ramp
// needing a real division first runs the restoring divider, which produces one
// quotient bit a cycle. Measure transfers stream at one per cycle as long as the
// queue of QUEUE_DEPTH jobs has room; the input is not ready while that queue is full.
// Results sit in an output register that is refilled as it drains.
// Configuration may only be written while the block holds no undelivered colour point.
module point_cloud_colorizer #(
    parameter int FRAC_BITS   = 16,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  pcc_pkg::t_in_item                i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output pcc_pkg::t_out_item               o_out_data
);
    logic          in_accept;
    logic          push, q_full, q_valid, pop;
    pcc_pkg::t_job front_job, back_job;

    // The front end accepts whenever the queue can take a job.
    assign o_in_ready = !q_full;
    assign in_accept  = i_in_valid && !q_full;

    pcc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (in_accept),
        .i_item      (i_in_data),
        .o_push      (push),
        .o_job       (front_job)
    );

    pcc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (back_job)
    );

    pcc_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (back_job),
        .o_job_pop   (pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );
endmodule

// ===== src/pcc_queue.sv =====
// Small first-word-fall-through queue of colour jobs between the front and back ends.
module pcc_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pcc_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pcc_pkg::t_job o_job
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pcc_pkg::t_job    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end
endmodule

// ===== src/pcc_front.sv =====
// Front end: configuration registers, extent tracking and classification of colour points.
module pcc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [pcc_pkg::CFG_INDEX_W-1:0]     i_cfg_index,
    input  logic [pcc_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    input  logic                                i_accept,
    input  pcc_pkg::t_in_item                   i_item,
    output logic                                o_push,
    output pcc_pkg::t_job                       o_job
);
    logic [2:0]         r_mode;
    logic [23:0]        r_single;
    logic [19:0]        r_rmin, r_rmax;
    logic signed [23:0] r_h_lo, r_h_hi;
    logic signed [15:0] r_e_lo, r_e_hi;

    logic signed [25:0] v, lo, hi, den, num, den_a, num_a;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= pcc_pkg::MODE_RESET;
            r_single <= pcc_pkg::SINGLE_RESET;
            r_rmin   <= pcc_pkg::RMIN_RESET;
            r_rmax   <= pcc_pkg::RMAX_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pcc_pkg::CFG_COLOR_MODE:   r_mode   <= i_cfg_data[2:0];
                pcc_pkg::CFG_SINGLE_COLOR: r_single <= i_cfg_data[23:0];
                pcc_pkg::CFG_RANGE_MIN:    r_rmin   <= i_cfg_data[19:0];
                pcc_pkg::CFG_RANGE_MAX:    r_rmax   <= i_cfg_data[19:0];
                default: ;
            endcase
        end
    end

    // Extents follow the measure pass; a first point restarts them.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_lo <= '0;
            r_h_hi <= '0;
            r_e_lo <= '0;
            r_e_hi <= '0;
        end else if (i_accept && !i_item.op) begin
            if (i_item.first_of_scan) begin
                r_h_lo <= i_item.height_cm;
                r_h_hi <= i_item.height_cm;
                r_e_lo <= i_item.elevation_cdeg;
                r_e_hi <= i_item.elevation_cdeg;
            end else begin
                if (i_item.height_cm < r_h_lo) r_h_lo <= i_item.height_cm;
                if (i_item.height_cm > r_h_hi) r_h_hi <= i_item.height_cm;
                if (i_item.elevation_cdeg < r_e_lo) r_e_lo <= i_item.elevation_cdeg;
                if (i_item.elevation_cdeg > r_e_hi) r_e_hi <= i_item.elevation_cdeg;
            end
        end
    end

    always_comb begin
        unique case (r_mode)
            pcc_pkg::MODE_HEIGHT: begin
                v  = 26'(i_item.height_cm);
                lo = 26'(r_h_lo);
                hi = 26'(r_h_hi);
            end
            pcc_pkg::MODE_ELEVATION: begin
                v  = 26'(i_item.elevation_cdeg);
                lo = 26'(r_e_lo);
                hi = 26'(r_e_hi);
            end
            default: begin
                v  = $signed({6'd0, i_item.range_mm});
                lo = $signed({6'd0, r_rmin});
                hi = $signed({6'd0, r_rmax});
            end
        endcase
        den = hi - lo;
        num = v - lo;
        // Reversed bounds run the ramp backwards.
        den_a = (den < 0) ? -den : den;
        num_a = (den < 0) ? -num : num;
    end

    always_comb begin
        o_push = i_accept && i_item.op;
        o_job  = '0;
        o_job.num = num_a[pcc_pkg::NORM_W-1:0];
        o_job.den = den_a[pcc_pkg::NORM_W-1:0];
        o_job.sid = i_item.surface_id[14:0];
        priority if (r_mode == pcc_pkg::MODE_SINGLE) begin
            o_job.kind = pcc_pkg::KIND_DIRECT;
            o_job.rgb  = r_single;
        end else if (r_mode == pcc_pkg::MODE_RANGE || r_mode == pcc_pkg::MODE_HEIGHT ||
                     r_mode == pcc_pkg::MODE_ELEVATION) begin
            o_job.kind = pcc_pkg::KIND_RAMP;
            priority if (den == 0) o_job.norm = pcc_pkg::NORM_HALF;
            else if (num_a <= 0)   o_job.norm = pcc_pkg::NORM_ZERO;
            else if (num_a >= den_a) o_job.norm = pcc_pkg::NORM_ONE;
            else                   o_job.norm = pcc_pkg::NORM_DIV;
        end else if (i_item.surface_id < 0) begin
            o_job.kind = pcc_pkg::KIND_DIRECT;
            o_job.rgb  = pcc_pkg::GRAY_RGB;
        end else begin
            o_job.kind = pcc_pkg::KIND_PALETTE;
        end
    end
endmodule

// ===== src/pcc_back.sv =====
// Back end: fraction divider, colour ramp, palette lookup and the output register.
module pcc_back #(
    parameter int FRAC_BITS = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_job_valid,
    input  pcc_pkg::t_job       i_job,
    output logic                o_job_pop,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output pcc_pkg::t_out_item  o_out_data
);
    localparam int T_W   = FRAC_BITS + 1;
    localparam int S_W   = FRAC_BITS + 3;
    localparam int B_W   = FRAC_BITS + 9;
    localparam int CNT_W = $clog2(FRAC_BITS);
    localparam int NW    = pcc_pkg::NORM_W;
    localparam int MOD12_SHIFT_L = pcc_pkg::MOD12_SHIFT;
    localparam logic [T_W-1:0] ONE_Q  = T_W'(1) << FRAC_BITS;
    localparam logic [T_W-1:0] HALF_Q = T_W'(1) << (FRAC_BITS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_CH   = 3'd2;
    localparam logic [2:0] ST_CV   = 3'd3;
    localparam logic [2:0] ST_PAL  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic [NW-1:0]        r_rem, r_den;
    logic [FRAC_BITS-1:0] r_quo;
    logic [CNT_W-1:0]     r_cnt;
    logic [T_W-1:0]       r_t;
    logic [T_W-1:0]       r_c0, r_c1, r_c2;
    logic [11:0]          r_pq;
    logic [14:0]          r_sid;
    logic [23:0]          r_rgb;
    logic                 r_out_valid;
    pcc_pkg::t_out_item   r_out;

    logic [NW:0]          rem2;
    logic                 take;
    logic [S_W-1:0]       s;
    logic [1:0]           k;
    logic [T_W-1:0]       f, inv, c0, c1, c2;
    logic [31:0]          prod;
    logic [14:0]          q12;
    logic [14:0]          pal_rem;
    logic                 out_free;

    function automatic logic [7:0] to_byte(input logic [T_W-1:0] c);
        logic [B_W-1:0] w;
        w = (B_W'(c) << 8) - B_W'(c) + B_W'(HALF_Q);
        return w[FRAC_BITS +: 8];
    endfunction

    assign rem2 = {r_rem, 1'b0};
    assign take = (rem2 >= {1'b0, r_den});

    // Ramp over red, yellow, green and blue stops.
    always_comb begin
        s = S_W'(r_t) + (S_W'(r_t) << 1);
        k = (s[S_W-1:FRAC_BITS] > 3'd2) ? 2'd2 : s[FRAC_BITS +: 2];
        f = T_W'(s - (S_W'(k) << FRAC_BITS));
        inv = ONE_Q - f;
        unique case (k)
            2'd0:    begin c0 = ONE_Q; c1 = f;     c2 = '0; end
            2'd1:    begin c0 = inv;   c1 = ONE_Q; c2 = '0; end
            default: begin c0 = '0;    c1 = inv;   c2 = f;  end
        endcase
    end

    assign prod    = 32'(i_job.sid) * 32'(pcc_pkg::MOD12_RECIP);
    assign q12     = (15'(r_pq) << 3) + (15'(r_pq) << 2);
    assign pal_rem = r_sid - q12;

    assign out_free  = !r_out_valid || i_out_ready;
    assign o_job_pop = (r_state == ST_IDLE) && i_job_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_job_valid) begin
                    unique case (i_job.kind)
                        pcc_pkg::KIND_RAMP:    n_state = (i_job.norm == pcc_pkg::NORM_DIV) ?
                                                         ST_DIV : ST_CH;
                        pcc_pkg::KIND_PALETTE: n_state = ST_PAL;
                        default:               n_state = ST_OUT;
                    endcase
                end
            end
            ST_DIV:  if (r_cnt == CNT_W'(FRAC_BITS - 1)) n_state = ST_CH;
            ST_CH:   n_state = ST_CV;
            ST_CV:   n_state = ST_OUT;
            ST_PAL:  n_state = ST_OUT;
            ST_OUT:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_rem <= i_job.num;
                r_den <= i_job.den;
                r_cnt <= '0;
                r_rgb <= i_job.rgb;
                r_sid <= i_job.sid;
                r_pq  <= prod[MOD12_SHIFT_L +: 12];
                unique case (i_job.norm)
                    pcc_pkg::NORM_ZERO: r_t <= '0;
                    pcc_pkg::NORM_ONE:  r_t <= ONE_Q;
                    pcc_pkg::NORM_HALF: r_t <= HALF_Q;
                    default:            r_t <= '0;
                endcase
            end
            ST_DIV: begin
                r_rem <= take ? NW'(rem2 - {1'b0, r_den}) : rem2[NW-1:0];
                r_quo <= {r_quo[FRAC_BITS-2:0], take};
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(FRAC_BITS - 1)) begin
                    r_t <= {1'b0, r_quo[FRAC_BITS-2:0], take};
                end
            end
            ST_CH: begin
                r_c0 <= c0;
                r_c1 <= c1;
                r_c2 <= c2;
            end
            ST_CV: r_rgb <= {to_byte(r_c0), to_byte(r_c1), to_byte(r_c2)};
            ST_PAL: r_rgb <= pcc_pkg::palette_rgb(pal_rem[3:0]);
            ST_OUT: if (out_free) r_out <= r_rgb;
            default: ;
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
endmodule

// ===== src/pcc_checker.sv =====
// Port-level checker for the point colouriser and its binding to the top level.
module pcc_checker #(
    parameter int MAX_PENDING = 6
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_ready,
    input pcc_pkg::t_in_item  i_in_data,
    input logic               o_out_valid,
    input logic               i_out_ready,
    input pcc_pkg::t_out_item o_out_data
);
    logic [7:0] r_pending;
    logic       col_in, res_out;

    assign col_in  = i_in_valid && o_in_ready && i_in_data.op;
    assign res_out = o_out_valid && i_out_ready;

    // Colour transfers taken in but whose result has not yet been transferred out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else if (col_in && !res_out) begin
            r_pending <= r_pending + 1'b1;
        end else if (res_out && !col_in) begin
            r_pending <= r_pending - 1'b1;
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("result valid straight after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed or dropped");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending == 8'd0 |-> !o_out_valid)
        else $error("result without an outstanding colour point");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= 8'(MAX_PENDING))
        else $error("more colour points outstanding than the block can hold");
endmodule

bind point_cloud_colorizer pcc_checker #(
    .MAX_PENDING (QUEUE_DEPTH + 2)
) u_pcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

// ===== bench/tb_point_cloud_colorizer.sv =====
// Self-checking testbench for the lidar point colouriser: directed corners, then random scans.
module tb_point_cloud_colorizer;
    timeunit 1ns;
    timeprecision 1ps;

    // The bench models the default fraction width so that ramp colours can be worked out
    // here bit for bit.
    localparam int FRAC_BITS = 16;
    localparam longint ONE_Q  = longint'(1) << FRAC_BITS;
    localparam longint HALF_Q = ONE_Q >> 1;

    // Modes above the elevation ramp are not named in the package. Everything from the
    // surface palette upwards colours by surface id.
    localparam logic [2:0] MODE_SURFACE = 3'd4;
    localparam logic [2:0] MODE_LAST    = 3'd7;

    localparam logic OP_MEASURE = 1'b0;
    localparam logic OP_COLOUR  = 1'b1;

    localparam logic [19:0] RANGE_TOP = 20'hFFFFF;

    // After the last expected colour has left, the settle wait is long enough for any work
    // still inside the block to settle before the configuration is touched.
    localparam int SETTLE_CYCLES = 2 * (FRAC_BITS + 4) + 8;

    // The slowest correct run is roughly 1330 transfers, plus the pauses around every
    // configuration phase. The limit sits several times above that.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_POINTS = 1300;
    localparam int PHASE_POINTS  = 110;
    localparam int QUIET_TAIL    = 200;
    localparam int MAX_REPORTS   = 40;

    // Colour predictor and store of expected colours. It keeps its own copy of the
    // registers and of the height and elevation extents, updated as transfers are
    // accepted, so that each colour is worked out against the state the block saw.
    class colour_scoreboard;
        logic [2:0]         mode;
        logic [23:0]        single_rgb;
        logic [19:0]        range_lo_mm;
        logic [19:0]        range_hi_mm;
        logic signed [23:0] height_lo;
        logic signed [23:0] height_hi;
        logic signed [15:0] elev_lo;
        logic signed [15:0] elev_hi;
        logic [23:0]        surface_palette [12];
        pcc_pkg::t_out_item expected_colours [$];
        int                 errors;
        int                 colours_checked;
        int                 measures_seen;

        function new();
            mode        = pcc_pkg::MODE_RESET;
            single_rgb  = pcc_pkg::SINGLE_RESET;
            range_lo_mm = pcc_pkg::RMIN_RESET;
            range_hi_mm = pcc_pkg::RMAX_RESET;
            height_lo   = '0;
            height_hi   = '0;
            elev_lo     = '0;
            elev_hi     = '0;
            surface_palette = '{24'hFF0000, 24'h00FF00, 24'h0000FF, 24'hFFFF00,
                                24'h00FFFF, 24'hFF00FF, 24'hFF8000, 24'h8000FF,
                                24'h008080, 24'hFF66B3, 24'h80FF00, 24'h8C5926};
        endfunction

        function void write_reg(logic [pcc_pkg::CFG_INDEX_W-1:0] idx,
                                logic [pcc_pkg::CFG_DATA_W-1:0] value);
            case (idx)
                pcc_pkg::CFG_COLOR_MODE:   mode        = value[2:0];
                pcc_pkg::CFG_SINGLE_COLOR: single_rgb  = value[23:0];
                pcc_pkg::CFG_RANGE_MIN:    range_lo_mm = value[19:0];
                pcc_pkg::CFG_RANGE_MAX:    range_hi_mm = value[19:0];
                default:                   ;
            endcase
        endfunction

        // Clamped position of v between lo and hi as an unsigned Q1.FRAC_BITS fraction. Reversed
        // bounds run the ramp backwards; equal bounds park it half way.
        function longint ramp_position(longint v, longint lo, longint hi);
            longint span;
            longint d;
            span = hi - lo;
            d    = v - lo;
            if (span == 0)
                return HALF_Q;
            if (span < 0) begin
                span = -span;
                d    = -d;
            end
            if (d <= 0)
                return 0;
            if (d >= span)
                return ONE_Q;
            return (d << FRAC_BITS) / span;
        endfunction

        function logic [7:0] chan_byte(longint c);
            return 8'((c * 255 + HALF_Q) >> FRAC_BITS);
        endfunction

        function pcc_pkg::t_out_item predict_colour(pcc_pkg::t_in_item p);
            longint      t;
            longint      s;
            longint      seg;
            longint      f;
            longint      inv;
            int          sid;
            logic        on_ramp;
            logic [23:0] rgb;
            t       = 0;
            on_ramp = 1'b1;
            rgb     = '0;
            case (mode)
                pcc_pkg::MODE_SINGLE: begin
                    on_ramp = 1'b0;
                    rgb     = single_rgb;
                end
                pcc_pkg::MODE_RANGE:
                    t = ramp_position(p.range_mm, range_lo_mm, range_hi_mm);
                pcc_pkg::MODE_HEIGHT:
                    t = ramp_position($signed(p.height_cm), height_lo, height_hi);
                pcc_pkg::MODE_ELEVATION:
                    t = ramp_position($signed(p.elevation_cdeg), elev_lo, elev_hi);
                default: begin
                    on_ramp = 1'b0;
                    sid     = $signed(p.surface_id);
                    rgb     = (sid < 0) ? 24'h808080 : surface_palette[sid % 12];
                end
            endcase
            if (on_ramp) begin
                // Three segments: red to yellow, yellow to green, green to blue. The top
                // of the ramp stays in the last segment.
                s   = 3 * t;
                seg = s >> FRAC_BITS;
                if (seg > 2)
                    seg = 2;
                f   = s - (seg << FRAC_BITS);
                inv = ONE_Q - f;
                if (seg == 0)
                    rgb = {chan_byte(ONE_Q), chan_byte(f), chan_byte(0)};
                else if (seg == 1)
                    rgb = {chan_byte(inv), chan_byte(ONE_Q), chan_byte(0)};
                else
                    rgb = {chan_byte(0), chan_byte(inv), chan_byte(f)};
            end
            return pcc_pkg::t_out_item'(rgb);
        endfunction

        function void note_point(pcc_pkg::t_in_item p);
            logic signed [23:0] h;
            logic signed [15:0] e;
            h = p.height_cm;
            e = p.elevation_cdeg;
            if (p.op == OP_MEASURE) begin
                measures_seen++;
                if (p.first_of_scan) begin
                    height_lo = h;
                    height_hi = h;
                    elev_lo   = e;
                    elev_hi   = e;
                end else begin
                    if (h < height_lo) height_lo = h;
                    if (h > height_hi) height_hi = h;
                    if (e < elev_lo)   elev_lo   = e;
                    if (e > elev_hi)   elev_hi   = e;
                end
            end else begin
                expected_colours.push_back(predict_colour(p));
            end
        endfunction

        function void report_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: %s mismatch, expected %0d, actual %0d",
                             $time, name, want, got);
            end
        endfunction

        function void check_colour(pcc_pkg::t_out_item got);
            pcc_pkg::t_out_item want;
            if (expected_colours.size() == 0) begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $display("%0t ns: colour %h arrived, expected none", $time, got);
                return;
            end
            want = expected_colours.pop_front();
            colours_checked++;
            report_field("red",   want.red,   got.red);
            report_field("green", want.green, got.green);
            report_field("blue",  want.blue,  got.blue);
        endfunction

        function int pending();
            return expected_colours.size();
        endfunction
    endclass

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [pcc_pkg::CFG_INDEX_W-1:0] i_cfg_index;
    logic [pcc_pkg::CFG_DATA_W-1:0]  i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    pcc_pkg::t_in_item               i_in_data;
    logic                            o_out_valid;
    logic                            i_out_ready;
    pcc_pkg::t_out_item              o_out_data;

    colour_scoreboard sb = new();

    // When set, neither side inserts idle cycles. Used for quiet stretches and for the
    // tail of the run.
    bit quiet;
    int points_sent;
    int phases_run;
    int cycle_count;

    point_cloud_colorizer #(
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        cycle_count = 0;
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timed out after %0d cycles with %0d colours outstanding.",
                 cycle_count, sb.pending());
        $display("FAIL point_cloud_colorizer");
        $finish;
    end

    // Every accepted colour is compared with the oldest prediction. Outputs are sampled
    // at the rising edge, before the block's own updates for that edge take effect.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_colour(o_out_data);
    end

    // Receiver: ready is mostly high, with stalls of random length dropped in at random
    // unless the run is in a quiet stretch. Ready changes only at the falling edge.
    initial begin
        int stall_left;
        i_out_ready = 1'b0;
        stall_left  = 0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!quiet && $urandom_range(0, 11) == 0)
                    stall_left = $urandom_range(1, 13);
            end
        end
    end

    function automatic pcc_pkg::t_in_item make_point(logic op, logic first_flag, int range_v,
                                                     int height_v, int elev_v, int sid_v);
        pcc_pkg::t_in_item p;
        p.op             = op;
        p.first_of_scan  = first_flag;
        p.range_mm       = 20'(range_v);
        p.height_cm      = 24'(height_v);
        p.elevation_cdeg = 16'(elev_v);
        p.surface_id     = 16'(sid_v);
        return p;
    endfunction

    // Random point whose range leans towards the current range bounds, so that the ramp
    // is exercised both inside and at the clamps.
    function automatic pcc_pkg::t_in_item random_point(logic op, logic first_flag);
        pcc_pkg::t_in_item p;
        int unsigned lo;
        int unsigned hi;
        lo = (sb.range_lo_mm < sb.range_hi_mm) ? sb.range_lo_mm : sb.range_hi_mm;
        hi = (sb.range_lo_mm < sb.range_hi_mm) ? sb.range_hi_mm : sb.range_lo_mm;
        p.op            = op;
        p.first_of_scan = first_flag;
        case ($urandom_range(0, 3))
            0:       p.range_mm = 20'($urandom);
            3:       p.range_mm = 20'(($urandom_range(0, 1) ? hi : lo) + $urandom_range(0, 2) - 1);
            default: p.range_mm = 20'($urandom_range(hi, lo));
        endcase
        if ($urandom_range(0, 3) == 0)
            p.height_cm = 24'($urandom);
        else
            p.height_cm = 24'(int'($urandom_range(0, 4000)) - 2000);
        p.elevation_cdeg = 16'(int'($urandom_range(0, 36000)) - 18000);
        if ($urandom_range(0, 1) == 0)
            p.surface_id = 16'($urandom);
        else
            p.surface_id = 16'($urandom_range(0, 40));
        return p;
    endfunction

    // Presents one point and holds it until the transfer completes. A random idle burst
    // may come first. Valid is never lowered between two back-to-back points.
    task automatic send_point(input pcc_pkg::t_in_item p);
        int gap;
        if (!quiet && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= p;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_point(p);
        points_sent++;
    endtask

    // Stops the input, waits for every predicted colour, then lets the block settle.
    task automatic drain_colours();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [pcc_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [pcc_pkg::CFG_DATA_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_reg(idx, value);
    endtask

    // A new phase: the block is drained first, then all four registers are written.
    task automatic configure(input logic [2:0] mode, input logic [23:0] rgb,
                             input logic [19:0] lo_mm, input logic [19:0] hi_mm);
        drain_colours();
        write_reg(pcc_pkg::CFG_COLOR_MODE,   pcc_pkg::CFG_DATA_W'(mode));
        write_reg(pcc_pkg::CFG_SINGLE_COLOR, pcc_pkg::CFG_DATA_W'(rgb));
        write_reg(pcc_pkg::CFG_RANGE_MIN,    pcc_pkg::CFG_DATA_W'(lo_mm));
        write_reg(pcc_pkg::CFG_RANGE_MAX,    pcc_pkg::CFG_DATA_W'(hi_mm));
        phases_run++;
    endtask

    task automatic random_settings();
        int          pick;
        logic [2:0]  mode;
        logic [19:0] lo_mm;
        logic [19:0] hi_mm;
        logic [19:0] swap;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            mode = pcc_pkg::MODE_SINGLE;
        else if (pick <= 2)
            mode = pcc_pkg::MODE_RANGE;
        else if (pick <= 4)
            mode = pcc_pkg::MODE_HEIGHT;
        else if (pick <= 6)
            mode = pcc_pkg::MODE_ELEVATION;
        else if (pick <= 8)
            mode = MODE_SURFACE;
        else
            mode = 3'($urandom_range(MODE_SURFACE + 1, MODE_LAST));
        lo_mm = 20'($urandom_range(0, 500000));
        hi_mm = 20'(lo_mm + $urandom_range(1, 500000));
        case ($urandom_range(0, 5))
            0: begin
                lo_mm = '0;
                hi_mm = RANGE_TOP;
            end
            1: hi_mm = lo_mm;
            2: begin
                swap  = lo_mm;
                lo_mm = hi_mm;
                hi_mm = swap;
            end
            default: ;
        endcase
        configure(mode, 24'($urandom), lo_mm, hi_mm);
    endtask

    // One scan sent twice: a measure pass that usually restarts the extents at its first
    // point, then a colour pass over the same points. A few transfers are replaced by
    // noise, a few colour points fall outside the scan, and the odd scan does not restart at its first point.
    task automatic run_scan();
        pcc_pkg::t_in_item pts [$];
        pcc_pkg::t_in_item p;
        int                n;
        logic              first_flag;
        n = $urandom_range(1, 16);
        for (int i = 0; i < n; i++) begin
            if (i == 0)
                first_flag = ($urandom_range(0, 9) != 0);
            else
                first_flag = ($urandom_range(0, 19) == 0);
            p = random_point(OP_MEASURE, first_flag);
            pts.push_back(p);
            if ($urandom_range(0, 12) == 0)
                p = random_point(1'($urandom), 1'($urandom));
            send_point(p);
        end
        foreach (pts[i]) begin
            p               = pts[i];
            p.op            = OP_COLOUR;
            p.first_of_scan = 1'($urandom);
            if ($urandom_range(0, 9) == 0)
                p = random_point(OP_COLOUR, 1'($urandom));
            send_point(p);
        end
    endtask

    initial begin
        int random_start;
        int phase_start;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        quiet       = 1'b0;
        points_sent = 0;
        phases_run  = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: range ramp over 0 to 100 m. Bottom, top, beyond the top and the
        // middle. A first_of_scan flag on a colour point must be ignored.
        send_point(make_point(OP_COLOUR, 1'b1, 0, 0, 0, 5));
        send_point(make_point(OP_COLOUR, 1'b0, 100000, 0, 0, 0));
        send_point(make_point(OP_COLOUR, 1'b0, 1048575, 0, 0, 0));
        send_point(make_point(OP_COLOUR, 1'b1, 50000, 0, 0, 0));

        // Height ramp before any measure point: the extents are still empty, so the ramp
        // sits half way. Then the widest possible scan and points at both ends.
        configure(pcc_pkg::MODE_HEIGHT, pcc_pkg::SINGLE_RESET, pcc_pkg::RMIN_RESET,
                  pcc_pkg::RMAX_RESET);
        send_point(make_point(OP_COLOUR, 1'b0, 0, 1234, 0, 0));
        send_point(make_point(OP_MEASURE, 1'b1, 0, -8388608, -18000, -32768));
        send_point(make_point(OP_MEASURE, 1'b0, 1048575, 8388607, 18000, 32767));
        send_point(make_point(OP_COLOUR, 1'b0, 0, -8388608, 0, 0));
        send_point(make_point(OP_COLOUR, 1'b0, 0, 8388607, 0, 0));
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 0));

        // Elevation ramp over the full beam, then a one-point scan whose span is zero.
        configure(pcc_pkg::MODE_ELEVATION, pcc_pkg::SINGLE_RESET, pcc_pkg::RMIN_RESET,
                  pcc_pkg::RMAX_RESET);
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 18000, 0));
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, -18000, 0));
        send_point(make_point(OP_MEASURE, 1'b1, 0, 77, 500, 0));
        send_point(make_point(OP_COLOUR, 1'b0, 0, 77, 500, 0));

        // Surface palette: misses come out grey, the rest wrap round the twelve entries.
        configure(MODE_SURFACE, pcc_pkg::SINGLE_RESET, pcc_pkg::RMIN_RESET,
                  pcc_pkg::RMAX_RESET);
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, -32768));
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 32767));
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 11));

        // Mode codes without a meaning of their own behave as the surface palette.
        for (int m = MODE_SURFACE + 1; m <= MODE_LAST; m++) begin
            configure(3'(m), pcc_pkg::SINGLE_RESET, pcc_pkg::RMIN_RESET,
                      pcc_pkg::RMAX_RESET);
            send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 9 + m));
        end

        // Single colour at both extremes.
        configure(pcc_pkg::MODE_SINGLE, 24'h000000, pcc_pkg::RMIN_RESET,
                  pcc_pkg::RMAX_RESET);
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 0));
        configure(pcc_pkg::MODE_SINGLE, 24'hFFFFFF, pcc_pkg::RMIN_RESET,
                  pcc_pkg::RMAX_RESET);
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 0));

        // Range bounds reversed across the whole field, then equal, then in order.
        configure(pcc_pkg::MODE_RANGE, 24'h123456, RANGE_TOP, 20'd0);
        send_point(make_point(OP_COLOUR, 1'b0, 0, 0, 0, 0));
        send_point(make_point(OP_COLOUR, 1'b0, 300000, 0, 0, 0));
        configure(pcc_pkg::MODE_RANGE, 24'h123456, 20'd4000, 20'd4000);
        send_point(make_point(OP_COLOUR, 1'b0, 4000, 0, 0, 0));
        configure(pcc_pkg::MODE_RANGE, 24'h123456, 20'd0, RANGE_TOP);
        send_point(make_point(OP_COLOUR, 1'b0, 1048575, 0, 0, 0));

        // Random phases of whole scans. Some phases run without idling, and so does the
        // tail of the run.
        random_start = points_sent;
        while (points_sent - random_start < RANDOM_POINTS) begin
            random_settings();
            quiet = ($urandom_range(0, 3) == 0)
                    || (points_sent - random_start > RANDOM_POINTS - QUIET_TAIL);
            phase_start = points_sent;
            while (points_sent - phase_start < PHASE_POINTS
                   && points_sent - random_start < RANDOM_POINTS)
                run_scan();
        end

        quiet = 1'b1;
        drain_colours();

        $display("Sent %0d points in %0d configuration phases: %0d measure points.",
                 points_sent, phases_run, sb.measures_seen);
        $display("Checked %0d colours across all modes; %0d errors, %0d colours missing.",
                 sb.colours_checked, sb.errors, sb.pending());
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS point_cloud_colorizer");
        else
            $display("FAIL point_cloud_colorizer");
        $finish;
    end

endmodule
